// ----- src/quintic_spline_sph_kernel_assert.svh -----
// Assertion macros shared by the kernel checker.
`ifndef QUINTIC_SPLINE_SPH_KERNEL_ASSERT_SVH
`define QUINTIC_SPLINE_SPH_KERNEL_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define QSK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qsk assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define QSK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qsk assertion failed");

`endif

// ----- src/qsk_pkg.sv -----
package qsk_pkg;

    // Normalized distance lane value: Q2.16 between 0 and 3.0.
    localparam int unsigned D_W    = 18;
    // d^2 up to 9.0 in Q4.16, d^4 up to 81.0 in Q7.16, d^5 up to 243.0 in Q8.16.
    localparam int unsigned SQ_W   = 20;
    localparam int unsigned QUAD_W = 23;
    localparam int unsigned P5_W   = 24;
    // Clamped kernel sum before scaling.
    localparam int unsigned SUM_W  = 29;

    localparam logic [D_W-1:0] Q_ONE   = 18'd65536;
    localparam logic [D_W-1:0] Q_TWO   = 18'd131072;
    localparam logic [D_W-1:0] Q_THREE = 18'd196608;

    localparam logic [31:0] INV_H_RESET  = 32'd65536;
    localparam logic [31:0] WSCALE_RESET = 32'd174;

    // Register select bit of the configuration address.
    localparam logic REG_INV_H  = 1'b0;
    localparam logic REG_WSCALE = 1'b1;

    typedef logic [D_W-1:0]  fx_d_t;
    typedef logic [P5_W-1:0] fx_p5_t;

    typedef struct packed {
        logic s1;
        logic s2;
    } qsk_norm_ld_t;

    typedef struct packed {
        logic sq;
        logic quad;
        logic fifth;
    } qsk_pow_ld_t;

    typedef struct packed {
        logic s6;
        logic s7;
    } qsk_scale_ld_t;

endpackage

// ----- src/qsk_norm.sv -----
module qsk_norm
    import qsk_pkg::*;
(
    input  logic         clk,
    input  qsk_norm_ld_t ld,
    input  logic [31:0]  distance,
    input  logic [31:0]  inv_h,
    output logic         oor,
    output fx_d_t        d3,
    output fx_d_t        d2,
    output fx_d_t        d1
);

    logic [63:0] prod_reg;
    logic        oor_reg;
    fx_d_t       d3_reg;
    fx_d_t       d2_reg;
    fx_d_t       d1_reg;

    logic        oor_next;
    fx_d_t       q;
    fx_d_t       d3_next;
    fx_d_t       d2_next;
    fx_d_t       d1_next;

    // Stage 1: scale distance by the inverse smoothing length
    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            prod_reg <= 64'(distance) * 64'(inv_h);
        end
    end

    // Stage 2: range check on q and the three spline offsets
    always_comb
    begin
        q        = prod_reg[33:16];
        oor_next = (|prod_reg[63:34]) || (q >= Q_THREE);
        d3_next  = oor_next ? '0 : Q_THREE - q;
        d2_next  = (!oor_next && q < Q_TWO) ? Q_TWO - q : '0;
        d1_next  = (!oor_next && q < Q_ONE) ? Q_ONE - q : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ld.s2)
        begin
            oor_reg <= oor_next;
            d3_reg  <= d3_next;
            d2_reg  <= d2_next;
            d1_reg  <= d1_next;
        end
    end

    assign oor = oor_reg;
    assign d3  = d3_reg;
    assign d2  = d2_reg;
    assign d1  = d1_reg;

endmodule

// ----- src/qsk_pow5.sv -----
module qsk_pow5
    import qsk_pkg::*;
(
    input  logic        clk,
    input  qsk_pow_ld_t ld,
    input  fx_d_t       d,
    output fx_p5_t      p5
);

    logic [2*D_W-1:0]         sq_full;
    logic [2*SQ_W-1:0]        quad_full;
    logic [QUAD_W+D_W-1:0]    fifth_full;

    fx_d_t                    d_sq_reg;
    logic [SQ_W-1:0]          sq_reg;
    fx_d_t                    d_quad_reg;
    logic [QUAD_W-1:0]        quad_reg;
    fx_p5_t                   p5_reg;

    assign sq_full    = (2*D_W)'(d) * (2*D_W)'(d);
    assign quad_full  = (2*SQ_W)'(sq_reg) * (2*SQ_W)'(sq_reg);
    assign fifth_full = (QUAD_W+D_W)'(quad_reg) * (QUAD_W+D_W)'(d_quad_reg);

    // Square, keep d alongside for the last multiply
    always_ff @(posedge clk)
    begin
        if (ld.sq)
        begin
            sq_reg   <= sq_full[SQ_W+15:16];
            d_sq_reg <= d;
        end
    end

    // Fourth power
    always_ff @(posedge clk)
    begin
        if (ld.quad)
        begin
            quad_reg   <= quad_full[QUAD_W+15:16];
            d_quad_reg <= d_sq_reg;
        end
    end

    // Fifth power
    always_ff @(posedge clk)
    begin
        if (ld.fifth)
        begin
            p5_reg <= fifth_full[P5_W+15:16];
        end
    end

    assign p5 = p5_reg;

endmodule

// ----- src/qsk_scale.sv -----
module qsk_scale
    import qsk_pkg::*;
(
    input  logic          clk,
    input  qsk_scale_ld_t ld,
    input  fx_p5_t        p3,
    input  fx_p5_t        p2,
    input  fx_p5_t        p1,
    input  logic          oor_in,
    input  logic [31:0]   wscale,
    output logic [31:0]   weight,
    output logic          oor
);

    logic [SUM_W-1:0]       pos;
    logic [SUM_W-1:0]       neg;
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W+31:0]      scaled;
    logic [31:0]            weight_next;

    logic [SUM_W-1:0]       sum_reg;
    logic                   oor_s6_reg;
    logic [31:0]            weight_reg;
    logic                   oor_reg;

    // Stage 6: combine the three terms, clamp a negative sum to zero
    always_comb
    begin
        pos      = SUM_W'(p3) + SUM_W'({p1, 4'b0000}) - SUM_W'(p1);
        neg      = SUM_W'({p2, 2'b00}) + SUM_W'({p2, 1'b0});
        sum_next = (pos >= neg) ? pos - neg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ld.s6)
        begin
            sum_reg    <= sum_next;
            oor_s6_reg <= oor_in;
        end
    end

    // Stage 7: apply the weight scale and saturate
    always_comb
    begin
        scaled      = (SUM_W+32)'(sum_reg) * (SUM_W+32)'(wscale);
        weight_next = (|scaled[SUM_W+31:48]) ? 32'hFFFF_FFFF : scaled[47:16];
    end

    always_ff @(posedge clk)
    begin
        if (ld.s7)
        begin
            weight_reg <= weight_next;
            oor_reg    <= oor_s6_reg;
        end
    end

    assign weight = weight_reg;
    assign oor    = oor_reg;

endmodule

// ----- src/quintic_spline_sph_kernel.sv -----
// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_stall  distance
// response  out        rsp_valid / rsp_stall  weight, out_of_range
// config    in         APB (psel .. pready)   inv_smoothing_length, weight_scale
//
// Seven register stages: the q multiply, range check, three lanes of square,
// fourth and fifth power, term sum, then the weight-scale multiply.
// One distance is taken every cycle when unstalled.
// Reset clears all stage valid bits and loads the register defaults.
// A stall holds the output beat; bubbles ahead of it still close up.
module quintic_spline_sph_kernel
    import qsk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic [31:0] distance,

    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] weight,
    output logic        out_of_range,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NSTAGE = 7;

    logic [31:0]       inv_h_reg;
    logic [31:0]       wscale_reg;
    logic [NSTAGE:1]   valid_reg;
    logic [NSTAGE:1]   rdy;
    logic [5:3]        oor_pipe_reg;

    qsk_norm_ld_t      norm_ld;
    qsk_pow_ld_t       pow_ld;
    qsk_scale_ld_t     scale_ld;

    logic              oor_s2;
    fx_d_t             d3;
    fx_d_t             d2;
    fx_d_t             d1;
    fx_p5_t            p3;
    fx_p5_t            p2;
    fx_p5_t            p1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_h_reg  <= INV_H_RESET;
            wscale_reg <= WSCALE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_INV_H)
            begin
                inv_h_reg <= pwdata;
            end
            else
            begin
                wscale_reg <= pwdata;
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WSCALE) ? wscale_reg : inv_h_reg;

    // A stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        rdy[NSTAGE] = !valid_reg[NSTAGE] || !rsp_stall;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                valid_reg[1] <= req_valid;
            end
            for (int k = 2; k <= NSTAGE; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign norm_ld  = '{s1: rdy[1], s2: rdy[2]};
    assign pow_ld   = '{sq: rdy[3], quad: rdy[4], fifth: rdy[5]};
    assign scale_ld = '{s6: rdy[6], s7: rdy[7]};

    // Carry the range flag beside the power lanes
    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            oor_pipe_reg[3] <= oor_s2;
        end
        if (rdy[4])
        begin
            oor_pipe_reg[4] <= oor_pipe_reg[3];
        end
        if (rdy[5])
        begin
            oor_pipe_reg[5] <= oor_pipe_reg[4];
        end
    end

    qsk_norm u_norm (
        .clk      (clk),
        .ld       (norm_ld),
        .distance (distance),
        .inv_h    (inv_h_reg),
        .oor      (oor_s2),
        .d3       (d3),
        .d2       (d2),
        .d1       (d1)
    );

    qsk_pow5 u_pow_three (
        .clk (clk),
        .ld  (pow_ld),
        .d   (d3),
        .p5  (p3)
    );

    qsk_pow5 u_pow_two (
        .clk (clk),
        .ld  (pow_ld),
        .d   (d2),
        .p5  (p2)
    );

    qsk_pow5 u_pow_one (
        .clk (clk),
        .ld  (pow_ld),
        .d   (d1),
        .p5  (p1)
    );

    qsk_scale u_scale (
        .clk    (clk),
        .ld     (scale_ld),
        .p3     (p3),
        .p2     (p2),
        .p1     (p1),
        .oor_in (oor_pipe_reg[5]),
        .wscale (wscale_reg),
        .weight (weight),
        .oor    (out_of_range)
    );

    assign req_stall = !rdy[1];
    assign rsp_valid = valid_reg[NSTAGE];

endmodule

// ----- src/qsk_checker.sv -----
`include "quintic_spline_sph_kernel_assert.svh"

module qsk_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [31:0] weight,
    input  logic        out_of_range
);

    // An out-of-range beat always carries a zero weight
    `QSK_ASSERT_NOW(a_oor_zero, rsp_valid && out_of_range, weight == 32'd0)

    // Input backs up only behind a stalled output beat
    `QSK_ASSERT_NOW(a_stall_cause, !(rsp_valid && rsp_stall), !req_stall)

    // A stalled response beat holds
    `QSK_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(weight) && $stable(out_of_range))

    // A stalled request is offered again the next cycle
    `QSK_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid)

endmodule

bind quintic_spline_sph_kernel qsk_checker u_qsk_checker (.*);

// ----- verif/tb_quintic_spline_sph_kernel.sv -----
`timescale 1ns / 100ps

module tb_quintic_spline_sph_kernel;
    import qsk_pkg::*;

    localparam int PIPE_LATENCY   = 7;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_COUNT    = 8;

    localparam logic [63:0] FX_ONE   = 64'd65536;
    localparam logic [63:0] FX_TWO   = 64'd131072;
    localparam logic [63:0] FX_THREE = 64'd196608;
    localparam logic [63:0] WEIGHT_MAX = 64'h0000_0000_FFFF_FFFF;

    localparam logic [2:0] ADDR_INV_H  = {REG_INV_H, 2'b00};
    localparam logic [2:0] ADDR_WSCALE = {REG_WSCALE, 2'b00};

    typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

    typedef struct packed {
        logic [31:0] weight;
        logic        out_of_range;
    } kernel_out_t;

    typedef struct packed {
        logic [31:0] span;
        logic        typed;
        logic [31:0] weight;
        logic        out_of_range;
    } distance_row_t;

    typedef struct {
        logic [31:0] inv_h;
        logic [31:0] wscale;
        pace_t       pace;
        int          items;
        logic        burst;
    } kernel_phase_t;

    // Directed distances under the reset settings (inverse length 1.0, scale 174)
    localparam distance_row_t DIRECTED_ROWS [18] = '{
        '{32'h0000_0000, 1'b1, 32'd11484, 1'b0},  // q = 0, all three terms
        '{32'h0001_0000, 1'b1, 32'd4524,  1'b0},  // q = 1, inner term drops out
        '{32'h0002_0000, 1'b1, 32'd174,   1'b0},  // q = 2, outer term only
        '{32'h0003_0000, 1'b1, 32'd0,     1'b1},  // q = 3, first out of range
        '{32'hFFFF_FFFF, 1'b1, 32'd0,     1'b1},
        '{32'h8000_0000, 1'b1, 32'd0,     1'b1},
        '{32'hFFFF_0000, 1'b1, 32'd0,     1'b1},
        '{32'h5555_5555, 1'b1, 32'd0,     1'b1},
        '{32'h0002_FFFF, 1'b0, 32'd0,     1'b0},
        '{32'h0000_0001, 1'b0, 32'd0,     1'b0},
        '{32'h0000_FFFF, 1'b0, 32'd0,     1'b0},
        '{32'h0001_0001, 1'b0, 32'd0,     1'b0},
        '{32'h0001_FFFF, 1'b0, 32'd0,     1'b0},
        '{32'h0002_0001, 1'b0, 32'd0,     1'b0},
        '{32'h0000_8000, 1'b0, 32'd0,     1'b0},
        '{32'h0001_8000, 1'b0, 32'd0,     1'b0},
        '{32'h0002_8000, 1'b0, 32'd0,     1'b0},
        '{32'h0000_AAAA, 1'b0, 32'd0,     1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [31:0] distance = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] weight;
    logic        out_of_range;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the kernel registers
    logic [31:0] cfg_inv_h  = INV_H_RESET;
    logic [31:0] cfg_wscale = WSCALE_RESET;

    kernel_out_t   pending_weights[$];
    kernel_phase_t phase_plan[PHASE_COUNT];
    int            mismatch_count = 0;
    int            result_count = 0;
    int            quiet_cycles = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            burst_req = 0;
    int            burst_ack = 0;
    int            hold_left = 0;

    quintic_spline_sph_kernel DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .distance     (distance),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .weight       (weight),
        .out_of_range (out_of_range),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // d^5 in Q16.16 with truncation after every multiply
    function automatic logic [63:0] fifth_power(input logic [63:0] d);
        logic [63:0] d2;
        logic [63:0] d4;
        d2 = (d * d) >> 16;
        d4 = (d2 * d2) >> 16;
        return (d4 * d) >> 16;
    endfunction

    // Kernel value for one distance under the current shadow registers
    function automatic kernel_out_t quintic_weight(input logic [31:0] span);
        logic [63:0] q;
        longint      sum_fx;
        logic [63:0] scaled;
        kernel_out_t res;
        q = (64'(span) * 64'(cfg_inv_h)) >> 16;
        res.weight = '0;
        res.out_of_range = 1'b1;
        if (q >= FX_THREE)
            return res;
        sum_fx = longint'(fifth_power(FX_THREE - q));
        if (q < FX_TWO)
            sum_fx -= 6 * longint'(fifth_power(FX_TWO - q));
        if (q < FX_ONE)
            sum_fx += 15 * longint'(fifth_power(FX_ONE - q));
        // clamp a sum pushed negative by truncation
        if (sum_fx < 0)
            sum_fx = 0;
        scaled = (64'(sum_fx) * 64'(cfg_wscale)) >> 16;
        res.weight = (scaled > WEIGHT_MAX) ? 32'hFFFF_FFFF : scaled[31:0];
        res.out_of_range = 1'b0;
        return res;
    endfunction

    // Aim mostly at the normalized range 0..3.25 and the knots, plus raw values
    function automatic logic [31:0] pick_distance();
        logic [63:0] q_goal;
        logic [63:0] dist64;
        logic [31:0] pick;
        int          kind;
        kind = $urandom_range(9);
        if (kind <= 5)
        begin
            if (kind <= 3)
                q_goal = 64'($urandom_range(32'h0003_4000));
            else
            begin
                q_goal = 64'($urandom_range(3)) * FX_ONE + 64'($urandom_range(8));
                q_goal = (q_goal >= 4) ? q_goal - 4 : q_goal;
            end
            if (cfg_inv_h == '0)
                dist64 = 64'($urandom);
            else
                dist64 = (q_goal << 16) / 64'(cfg_inv_h);
            pick = (dist64 > WEIGHT_MAX) ? $urandom : dist64[31:0];
        end
        else if (kind <= 7)
            pick = $urandom;
        else
            pick = $urandom >> $urandom_range(31);
        return pick;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    // One APB transfer: setup, access, then release
    task automatic reg_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_check(input logic [2:0] addr, input logic [31:0] expected);
        logic [31:0] rd;
        reg_access(1'b0, addr, '0, rd);
        if (rd !== expected)
            note_mismatch($sformatf("register read at %0d: expected %h got %h",
                                    addr, expected, rd));
    endtask

    task automatic load_kernel_cfg(input logic [31:0] inv_h, input logic [31:0] wscale);
        logic [31:0] rd;
        reg_access(1'b1, ADDR_INV_H, inv_h, rd);
        reg_access(1'b1, ADDR_WSCALE, wscale, rd);
        cfg_inv_h  = inv_h;
        cfg_wscale = wscale;
        reg_check(ADDR_INV_H, inv_h);
        reg_check(ADDR_WSCALE, wscale);
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SLOW_SINK:
            begin
                send_idle_pct = 37;
                recv_idle_pct <= 72;
            end
            PACE_SLOW_SOURCE:
            begin
                send_idle_pct = 72;
                recv_idle_pct <= 37;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
        endcase
    endtask

    // Offer one distance after a random gap and hold it until taken
    task automatic send_distance(input logic [31:0] span, input logic typed,
                                 input kernel_out_t typed_res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        distance  <= span;
        do
            @(posedge clk);
        while (req_stall);
        pending_weights.push_back(typed ? typed_res : quintic_weight(span));
    endtask

    // Wait for every outstanding weight, then let the pipeline empty
    task automatic drain_pipeline();
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 3) @(posedge clk);
    endtask

    // Receiver: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (burst_req != burst_ack)
        begin
            burst_ack <= burst_req;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each output beat with the oldest predicted weight
    always @(posedge clk)
    begin
        kernel_out_t exp_res;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_weights.size() == 0)
                note_mismatch($sformatf("unexpected beat: weight %h out_of_range %b",
                                        weight, out_of_range));
            else
            begin
                exp_res = pending_weights.pop_front();
                if (weight !== exp_res.weight)
                    note_mismatch($sformatf("beat %0d weight: expected %h got %h",
                                            result_count, exp_res.weight, weight));
                if (out_of_range !== exp_res.out_of_range)
                    note_mismatch($sformatf("beat %0d out_of_range: expected %b got %b",
                                            result_count, exp_res.out_of_range,
                                            out_of_range));
            end
            result_count++;
        end
    end

    // Watchdog: stop when no beat moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_quintic_spline_sph_kernel: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        kernel_out_t row_res;
        phase_plan[0] = '{32'h0001_0000, 32'd174, PACE_SLOW_SINK, 320, 1'b0};
        phase_plan[1] = '{32'h0000_8000, $urandom_range(1, 32'hFFFF), PACE_SLOW_SINK,
                          250, 1'b0};
        phase_plan[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, PACE_SLOW_SOURCE, 150, 1'b0};
        // zero inverse length puts every distance at q = 0 and saturates the weight
        phase_plan[3] = '{32'h0000_0000, 32'hFFFF_FFFF, PACE_SLOW_SOURCE, 100, 1'b0};
        phase_plan[4] = '{32'h0002_0000, 32'h0000_0000, PACE_SLOW_SOURCE, 150, 1'b0};
        phase_plan[5] = '{$urandom, $urandom, PACE_FULL, 200, 1'b1};
        phase_plan[6] = '{32'h0001_0000, 32'h0001_0000, PACE_FULL, 300, 1'b0};
        phase_plan[7] = '{$urandom >> $urandom_range(8, 24),
                          $urandom_range(0, 32'h00FF_FFFF), PACE_FULL, 310, 1'b0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Check reset values, then walk the directed table
        set_pace(PACE_SLOW_SINK);
        reg_check(ADDR_INV_H, INV_H_RESET);
        reg_check(ADDR_WSCALE, WSCALE_RESET);
        foreach (DIRECTED_ROWS[i])
        begin
            row_res.weight       = DIRECTED_ROWS[i].weight;
            row_res.out_of_range = DIRECTED_ROWS[i].out_of_range;
            send_distance(DIRECTED_ROWS[i].span, DIRECTED_ROWS[i].typed, row_res);
        end
        req_valid <= 1'b0;
        drain_pipeline();

        // Random phases, each under its own register settings
        foreach (phase_plan[p])
        begin
            load_kernel_cfg(phase_plan[p].inv_h, phase_plan[p].wscale);
            set_pace(phase_plan[p].pace);
            if (phase_plan[p].burst)
                burst_req <= burst_req + 1;
            row_res = '0;
            for (int n = 0; n < phase_plan[p].items; n++)
                send_distance(pick_distance(), 1'b0, row_res);
            req_valid <= 1'b0;
            drain_pipeline();
        end

        if (mismatch_count == 0)
            $display("tb_quintic_spline_sph_kernel: done, clean");
        else
            $display("tb_quintic_spline_sph_kernel: done, errors");
        $finish;
    end

endmodule
